// File: sv/swts_pkg.sv
// Shared types, constants and codes for the sliding-window timing statistics block.
`default_nettype none

package swts_pkg;

    localparam int WINDOW_DEF = 512;
    localparam int SAMPLE_W   = 24;
    localparam int PCT_W      = 7;
    localparam int COUNT_W    = 10;
    localparam int INTERP_W   = SAMPLE_W + PCT_W;

    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    // Reciprocal of 100 scaled by 2**37; exact for every dividend below 2**32.
    localparam logic [31:0] RECIP100 = 32'h51EB851F;
    localparam int          RECIP_SH = 37;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [SAMPLE_W-1:0] sample;
        logic [PCT_W-1:0]    percent;
    } in_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] last_sample;
        logic [COUNT_W-1:0]  sample_count;
        logic [SAMPLE_W-1:0] mean_value;
        logic [SAMPLE_W-1:0] weighted_mean;
        logic [SAMPLE_W-1:0] max_all_time;
        logic [SAMPLE_W-1:0] max_recent;
        logic [SAMPLE_W-1:0] percentile_value;
    } out_t;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_WSQ
    } div_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_A_RDRING,
        ST_A_OLD,
        ST_A_REMOVE,
        ST_A_INS_INIT,
        ST_A_INSERT,
        ST_A_UPD,
        ST_A_SQSUB,
        ST_A_MEAN,
        ST_A_MEAN_W,
        ST_A_WSQ,
        ST_A_WSQ_W,
        ST_Q_START,
        ST_Q_DIV,
        ST_Q_REM,
        ST_Q_RDA,
        ST_Q_RDB,
        ST_Q_MUL1,
        ST_Q_MUL2,
        ST_Q_IDIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic     cap;
        logic     ring_rd;
        logic     old_ld;
        logic     rm_init;
        logic     rm_step;
        logic     ins_init;
        logic     ins_step;
        logic     upd;
        logic     sq_sub;
        logic     div_go;
        logic     div_st;
        div_sel_t div_sel;
        logic     pct_clr;
        logic     prod_ld;
        logic     lo_ld;
        logic     r_ld;
        logic     rd_a;
        logic     rd_b;
        logic     mul1;
        logic     mul2;
        logic     pct_ld;
    } ctl_t;

    typedef struct packed {
        logic rm_done;
        logic ins_done;
        logic div_done;
        logic empty;
        logic filled;
    } stat_t;

endpackage

`default_nettype wire

// File: sv/swts_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module swts_div #(
    parameter int NW = 60,
    parameter int DW = 36
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          go,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic [NW-1:0]      quo
);
    localparam int CNTW = $clog2(NW + 1);

    logic [CNTW-1:0] cnt_reg;
    logic            run_reg;
    logic            done_reg;
    logic [NW-1:0]   quo_reg;
    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   den_reg;
    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            ge;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (go)
        begin
            cnt_reg  <= CNTW'(NW);
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// File: sv/swts_dp.sv
// Datapath: sample ring, sorted copy, running sums, maxima and the shared divider.
`default_nettype none

module swts_dp #(
    parameter int WINDOW = swts_pkg::WINDOW_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire swts_pkg::in_t  item,
    input  wire swts_pkg::ctl_t ctl,
    output swts_pkg::stat_t     stat,
    output swts_pkg::out_t      result
);
    import swts_pkg::*;

    localparam int AW  = $clog2(WINDOW);
    localparam int CW  = $clog2(WINDOW + 1);
    localparam int TW  = SAMPLE_W + CW;
    localparam int SW  = 2 * SAMPLE_W + CW;
    localparam int PW  = PCT_W + CW;
    localparam int LPW = PW + 32;
    localparam int IPW = INTERP_W + 32;

    logic [SAMPLE_W-1:0] ring_mem [WINDOW];
    logic [SAMPLE_W-1:0] sort_mem [WINDOW];

    in_t                 item_reg;
    logic [AW-1:0]       slot_reg;
    logic                filled_reg;
    logic [TW-1:0]       total_reg;
    logic [SW-1:0]       sq_reg;
    logic [SAMPLE_W-1:0] mean_reg;
    logic [SAMPLE_W-1:0] wmean_reg;
    logic [SAMPLE_W-1:0] peak_ever_reg;
    logic [SAMPLE_W-1:0] peak_this_reg;
    logic [SAMPLE_W-1:0] peak_prior_reg;
    logic [SAMPLE_W-1:0] last_reg;
    logic [SAMPLE_W-1:0] pctl_reg;
    logic [SAMPLE_W-1:0] ring_q;
    logic [SAMPLE_W-1:0] sort_q;
    logic [SAMPLE_W-1:0] old_reg;
    logic [CW-1:0]       ridx_reg;
    logic [AW-1:0]       pend_idx_reg;
    logic                pend_v_reg;
    logic                found_reg;
    logic                active_reg;
    logic [PW-1:0]       prod_reg;
    logic [AW-1:0]       lo_reg;
    logic [PCT_W-1:0]    r_reg;
    logic [SAMPLE_W-1:0] a_reg;
    logic [INTERP_W-1:0] acc_reg;

    logic [CW-1:0]       n_held;
    logic [CW-1:0]       n_ins;
    logic [CW-1:0]       ridx_dec;
    logic [SAMPLE_W-1:0] mul_in;
    logic [2*SAMPLE_W-1:0] sqp;
    logic [SAMPLE_W-1:0] peak_this_new;
    logic [PCT_W-1:0]    pct_sat;
    logic [SAMPLE_W-1:0] b_eff;
    logic [LPW-1:0]      lo_prod;
    logic [IPW-1:0]      ip_prod;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [SAMPLE_W-1:0] wr_data;
    logic [SW-1:0]       div_num;
    logic [TW-1:0]       div_den;
    logic                div_done;
    logic [SW-1:0]       div_quo;

    assign n_held   = filled_reg ? CW'(WINDOW) : CW'(slot_reg);
    assign n_ins    = filled_reg ? CW'(WINDOW - 1) : CW'(slot_reg);
    assign ridx_dec = ridx_reg - CW'(1);
    assign mul_in   = ctl.sq_sub ? old_reg : item_reg.sample;
    assign sqp      = mul_in * mul_in;
    assign peak_this_new = (item_reg.sample > peak_this_reg) ? item_reg.sample : peak_this_reg;
    assign pct_sat  = (item_reg.percent > PCT_MAX) ? PCT_MAX : item_reg.percent;
    assign b_eff    = (r_reg == '0) ? '0 : sort_q;
    assign lo_prod  = LPW'(prod_reg) * LPW'(RECIP100);
    assign ip_prod  = IPW'(acc_reg) * IPW'(RECIP100);

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (ctl.rm_step)
        begin
            if (ridx_reg < n_held)
            begin
                rd_en   = 1'b1;
                rd_addr = ridx_reg[AW-1:0];
            end
            if (pend_v_reg && found_reg)
            begin
                wr_en   = 1'b1;
                wr_addr = pend_idx_reg - AW'(1);
                wr_data = sort_q;
            end
        end
        else if (ctl.ins_step)
        begin
            if (ridx_reg != '0)
            begin
                rd_en   = 1'b1;
                rd_addr = ridx_dec[AW-1:0];
            end
            if (pend_v_reg && active_reg)
            begin
                wr_en   = 1'b1;
                wr_addr = pend_idx_reg + AW'(1);
                wr_data = (sort_q > item_reg.sample) ? sort_q : item_reg.sample;
            end
            else if (!pend_v_reg && ridx_reg == '0 && active_reg)
            begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = item_reg.sample;
            end
        end
        else if (ctl.rd_a)
        begin
            rd_en   = 1'b1;
            rd_addr = lo_reg;
        end
        else if (ctl.rd_b)
        begin
            rd_en   = 1'b1;
            rd_addr = lo_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            sort_q <= sort_mem[rd_addr];
        end
        if (wr_en)
        begin
            sort_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ring_rd)
        begin
            ring_q <= ring_mem[slot_reg];
        end
        if (ctl.upd)
        begin
            ring_mem[slot_reg] <= item_reg.sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cap)
        begin
            item_reg <= item;
        end
        if (ctl.old_ld)
        begin
            old_reg <= filled_reg ? ring_q : '0;
        end
        if (ctl.prod_ld)
        begin
            prod_reg <= PW'(pct_sat) * PW'(n_held - CW'(1));
        end
        if (ctl.rm_step || ctl.ins_step)
        begin
            pend_idx_reg <= rd_addr;
        end
        if (ctl.rd_b)
        begin
            a_reg <= sort_q;
        end
        if (ctl.mul1)
        begin
            acc_reg <= INTERP_W'(a_reg) * INTERP_W'(PCT_MAX - r_reg);
        end
        else if (ctl.mul2)
        begin
            acc_reg <= acc_reg + INTERP_W'(b_eff) * INTERP_W'(r_reg);
        end
        if (ctl.lo_ld)
        begin
            lo_reg <= lo_prod[RECIP_SH +: AW];
        end
        if (ctl.r_ld)
        begin
            r_reg <= PCT_W'(prod_reg - PW'(lo_reg) * PW'(PCT_MAX));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ridx_reg   <= '0;
            pend_v_reg <= 1'b0;
            found_reg  <= 1'b0;
            active_reg <= 1'b0;
        end
        else if (ctl.rm_init)
        begin
            ridx_reg   <= '0;
            pend_v_reg <= 1'b0;
            found_reg  <= 1'b0;
        end
        else if (ctl.ins_init)
        begin
            ridx_reg   <= n_ins;
            pend_v_reg <= 1'b0;
            active_reg <= 1'b1;
        end
        else if (ctl.rm_step)
        begin
            pend_v_reg <= rd_en;
            if (rd_en)
            begin
                ridx_reg <= ridx_reg + CW'(1);
            end
            if (pend_v_reg && !found_reg && sort_q == old_reg)
            begin
                found_reg <= 1'b1;
            end
        end
        else if (ctl.ins_step)
        begin
            pend_v_reg <= rd_en;
            if (rd_en)
            begin
                ridx_reg <= ridx_dec;
            end
            if (wr_en && (wr_data == item_reg.sample))
            begin
                active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg       <= '0;
            filled_reg     <= 1'b0;
            total_reg      <= '0;
            sq_reg         <= '0;
            mean_reg       <= '0;
            wmean_reg      <= '0;
            peak_ever_reg  <= '0;
            peak_this_reg  <= '0;
            peak_prior_reg <= '0;
            last_reg       <= '0;
            pctl_reg       <= '0;
        end
        else
        begin
            if (ctl.cap || ctl.pct_clr)
            begin
                pctl_reg <= '0;
            end
            if (ctl.pct_ld)
            begin
                pctl_reg <= ip_prod[RECIP_SH +: SAMPLE_W];
            end
            if (ctl.upd)
            begin
                total_reg <= total_reg + TW'(item_reg.sample) - TW'(old_reg);
                sq_reg    <= sq_reg + SW'(sqp);
                last_reg  <= item_reg.sample;
                if (item_reg.sample > peak_ever_reg)
                begin
                    peak_ever_reg <= item_reg.sample;
                end
                if (slot_reg == AW'(WINDOW - 1))
                begin
                    slot_reg       <= '0;
                    filled_reg     <= 1'b1;
                    peak_prior_reg <= peak_this_new;
                    peak_this_reg  <= '0;
                end
                else
                begin
                    slot_reg      <= slot_reg + AW'(1);
                    peak_this_reg <= peak_this_new;
                end
            end
            if (ctl.sq_sub)
            begin
                sq_reg <= sq_reg - SW'(sqp);
            end
            if (ctl.div_st && div_done)
            begin
                case (ctl.div_sel)
                    DIV_MEAN: mean_reg  <= div_quo[SAMPLE_W-1:0];
                    DIV_WSQ:  wmean_reg <= (total_reg == '0) ? '0 : div_quo[SAMPLE_W-1:0];
                    default:  ;
                endcase
            end
        end
    end

    always_comb
    begin
        case (ctl.div_sel)
            DIV_MEAN:
            begin
                div_num = SW'(total_reg);
                div_den = TW'(n_held);
            end
            default:
            begin
                div_num = sq_reg;
                div_den = total_reg;
            end
        endcase
    end

    swts_div #(
        .NW(SW),
        .DW(TW)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (ctl.div_go),
        .num  (div_num),
        .den  (div_den),
        .done (div_done),
        .quo  (div_quo)
    );

    assign stat.rm_done  = (ridx_reg == n_held) && !pend_v_reg;
    assign stat.ins_done = !active_reg;
    assign stat.div_done = div_done;
    assign stat.empty    = (n_held == '0);
    assign stat.filled   = filled_reg;

    assign result.last_sample      = last_reg;
    assign result.sample_count     = COUNT_W'(n_held);
    assign result.mean_value       = mean_reg;
    assign result.weighted_mean    = wmean_reg;
    assign result.max_all_time     = peak_ever_reg;
    assign result.max_recent       = (peak_this_reg > peak_prior_reg) ? peak_this_reg
                                                                      : peak_prior_reg;
    assign result.percentile_value = pctl_reg;

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= AW'(WINDOW - 1))
        else $error("write slot beyond the window");

    a_one_scan: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.rm_step && ctl.ins_step))
        else $error("remove and insert scans overlap");

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        n_held <= CW'(WINDOW))
        else $error("held count beyond the window");

    a_lo_held: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rd_a |-> (CW'(lo_reg) < n_held))
        else $error("percentile index beyond the held samples");

endmodule

`default_nettype wire

// File: sv/swts_ctrl.sv
// Controller state machine that sequences add and query transactions.
`default_nettype none

module swts_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic            item_cmd,
    input  wire swts_pkg::stat_t stat,
    output swts_pkg::ctl_t       ctl,
    output logic                 busy,
    output logic                 done
);
    import swts_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ctl         = '0;
        ctl.div_sel = DIV_MEAN;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.cap    = 1'b1;
                    state_next = (item_cmd == CMD_QUERY) ? ST_Q_START : ST_A_RDRING;
                end
            end
            ST_A_RDRING:
            begin
                ctl.ring_rd = 1'b1;
                ctl.rm_init = 1'b1;
                state_next  = ST_A_OLD;
            end
            ST_A_OLD:
            begin
                ctl.old_ld = 1'b1;
                state_next = stat.filled ? ST_A_REMOVE : ST_A_INS_INIT;
            end
            ST_A_REMOVE:
            begin
                if (stat.rm_done)
                begin
                    state_next = ST_A_INS_INIT;
                end
                else
                begin
                    ctl.rm_step = 1'b1;
                end
            end
            ST_A_INS_INIT:
            begin
                ctl.ins_init = 1'b1;
                state_next   = ST_A_INSERT;
            end
            ST_A_INSERT:
            begin
                if (stat.ins_done)
                begin
                    state_next = ST_A_UPD;
                end
                else
                begin
                    ctl.ins_step = 1'b1;
                end
            end
            ST_A_UPD:
            begin
                ctl.upd    = 1'b1;
                state_next = ST_A_SQSUB;
            end
            ST_A_SQSUB:
            begin
                ctl.sq_sub = 1'b1;
                state_next = ST_A_MEAN;
            end
            ST_A_MEAN:
            begin
                ctl.div_go = 1'b1;
                state_next = ST_A_MEAN_W;
            end
            ST_A_MEAN_W:
            begin
                ctl.div_st = 1'b1;
                if (stat.div_done)
                begin
                    state_next = ST_A_WSQ;
                end
            end
            ST_A_WSQ:
            begin
                ctl.div_sel = DIV_WSQ;
                ctl.div_go  = 1'b1;
                state_next  = ST_A_WSQ_W;
            end
            ST_A_WSQ_W:
            begin
                ctl.div_sel = DIV_WSQ;
                ctl.div_st  = 1'b1;
                if (stat.div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_Q_START:
            begin
                if (stat.empty)
                begin
                    ctl.pct_clr = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    ctl.prod_ld = 1'b1;
                    state_next  = ST_Q_DIV;
                end
            end
            ST_Q_DIV:
            begin
                ctl.lo_ld  = 1'b1;
                state_next = ST_Q_REM;
            end
            ST_Q_REM:
            begin
                ctl.r_ld   = 1'b1;
                state_next = ST_Q_RDA;
            end
            ST_Q_RDA:
            begin
                ctl.rd_a   = 1'b1;
                state_next = ST_Q_RDB;
            end
            ST_Q_RDB:
            begin
                ctl.rd_b   = 1'b1;
                state_next = ST_Q_MUL1;
            end
            ST_Q_MUL1:
            begin
                ctl.mul1   = 1'b1;
                state_next = ST_Q_MUL2;
            end
            ST_Q_MUL2:
            begin
                ctl.mul2   = 1'b1;
                state_next = ST_Q_IDIV;
            end
            ST_Q_IDIV:
            begin
                ctl.pct_ld = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not make the block busy");

    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after delivering a result");

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

endmodule

`default_nettype wire

// File: sv/sliding_window_timing_stats_core.sv
// Top level of the sliding-window timing statistics block.
//
// A transaction is accepted at a rising edge with start high and busy low. The
// item carries a command: add a duration sample, or query a percentile of the
// samples held in the window. Each transaction produces exactly one result,
// shown on result for one cycle with done high; the receiver cannot stall it.
// An add walks the sorted copy once, when the ring has filled, to take out the
// overwritten sample, and once to insert the new one, then runs two divisions
// for the mean and the weighted mean. Its length is set by the scans of the
// sorted memory and by the divider, which yields one quotient bit per cycle.
// A query's two divisions by 100 are reciprocal multiplies. An empty window
// answers a query with a percentile of 0.
// Only one transaction is in flight; busy stays high through the done cycle,
// so the next transaction can be accepted in the cycle after done.
// Reset clears all statistics at once; the sample ring needs no clearing pass,
// since the overwritten sample counts as zero until the ring has filled.
`default_nettype none

module sliding_window_timing_stats_core #(
    parameter int WINDOW = swts_pkg::WINDOW_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire swts_pkg::in_t item,
    output logic               busy,
    output logic               done,
    output swts_pkg::out_t     result
);
    import swts_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    swts_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .item_cmd(item.cmd),
        .stat    (stat),
        .ctl     (ctl),
        .busy    (busy),
        .done    (done)
    );

    swts_dp #(
        .WINDOW(WINDOW)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .ctl   (ctl),
        .stat  (stat),
        .result(result)
    );

endmodule

`default_nettype wire
